/* design/ibw_pkg.sv */
// Types and constants shared by the wildcard ban table.
// No dependencies.
package ibw_pkg;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic [7:0]         WILDCARD_OCTET = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [TIME_W-1:0]  EXPIRY_PERM    = '0;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_PERMANENT = 2'd1,
        STATUS_TIME_LEFT = 2'd2
    } status_t;

    // Operation travelling down the cell row
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [TIME_W-1:0]  expiry;
        logic [TIME_W-1:0]  now_time;
        logic               done;
        status_t            status;
        logic [COUNT_W-1:0] removed;
    } token_t;

endpackage

/* design/ibw_req_if.sv */
// Request channel: operation kind, address and times.
// Depends on ibw_pkg.
interface ibw_req_if
    import ibw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output kind, output address, output expiry,
                    output now_time, input ready);
    modport sink   (input valid, input kind, input address, input expiry,
                    input now_time, output ready);
endinterface

/* design/ibw_rsp_if.sv */
// Response channel: lookup status, full flag and removed count.
// Depends on ibw_pkg.
interface ibw_rsp_if
    import ibw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               table_full;
    logic [COUNT_W-1:0] removed_count;

    modport source (output valid, output status, output table_full,
                    output removed_count, input ready);
    modport sink   (input valid, input status, input table_full,
                    input removed_count, output ready);
endinterface

/* design/ibw_cell.sv */
// One table slot: valid bit, address and expiry, plus the token register
// that hands the operation on to the next slot. Depends on ibw_pkg.
module ibw_cell
    import ibw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  token_t tok_in,
    output token_t tok_out
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] expiry_reg;
    token_t            tok_reg, tok_next;
    logic              write;

    function automatic logic octets_match(input logic [ADDR_W-1:0] stored,
                                          input logic [ADDR_W-1:0] addr);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (stored[8*k +: 8] != addr[8*k +: 8] && stored[8*k +: 8] != WILDCARD_OCTET)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] n);
        return (n == COUNT_MAX) ? n : n + 1'b1;
    endfunction

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        write      = 1'b0;
        if (tok_in.valid)
        begin
            case (tok_in.kind)
                KIND_LOOKUP:
                begin
                    if (!tok_in.done && valid_reg && octets_match(addr_reg, tok_in.address))
                    begin
                        tok_next.done = 1'b1;
                        if (expiry_reg == EXPIRY_PERM)
                        begin
                            tok_next.status = STATUS_PERMANENT;
                        end
                        else if (expiry_reg > tok_in.now_time)
                        begin
                            tok_next.status = STATUS_TIME_LEFT;
                        end
                        else
                        begin
                            valid_next       = 1'b0;
                            tok_next.removed = sat_inc(tok_in.removed);
                        end
                    end
                end
                KIND_ADD:
                begin
                    if (!tok_in.done && !valid_reg)
                    begin
                        valid_next    = 1'b1;
                        write         = 1'b1;
                        tok_next.done = 1'b1;
                    end
                end
                KIND_REMOVE:
                begin
                    if (valid_reg && addr_reg == tok_in.address)
                    begin
                        valid_next       = 1'b0;
                        tok_next.removed = sat_inc(tok_in.removed);
                    end
                end
                KIND_CLEAR:
                begin
                    if (valid_reg)
                    begin
                        valid_next       = 1'b0;
                        tok_next.removed = sat_inc(tok_in.removed);
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && write)
        begin
            addr_reg   <= tok_in.address;
            expiry_reg <= tok_in.expiry;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* design/ip_ban_wildcard_table_core.sv */
// Wildcard IPv4 ban table: a row of TABLE_ENTRIES slot cells.
// Operations pass each slot token register, then the response register.
// Throughput: one operation per cycle; each operation moves one slot per
// cycle down the cell row, later operations following right behind.
// The whole row stalls while the response register is full and not taken.
// Reset clears every slot valid bit and all in-flight operations at once.
module ip_ban_wildcard_table_core
    import ibw_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    ibw_req_if.sink   req,
    ibw_rsp_if.source rsp
);

    token_t             tok [TABLE_ENTRIES+1];
    logic               advance;
    logic               rsp_valid_reg;
    status_t            status_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] removed_reg;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = advance;

    always_comb
    begin
        tok[0].valid    = req.valid;
        tok[0].kind     = kind_t'(req.kind);
        tok[0].address  = req.address;
        tok[0].expiry   = req.expiry;
        tok[0].now_time = req.now_time;
        tok[0].done     = 1'b0;
        tok[0].status   = STATUS_NONE;
        tok[0].removed  = '0;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        ibw_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= tok[TABLE_ENTRIES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= tok[TABLE_ENTRIES].status;
            full_reg    <= (tok[TABLE_ENTRIES].kind == KIND_ADD) && !tok[TABLE_ENTRIES].done;
            removed_reg <= tok[TABLE_ENTRIES].removed;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.table_full    = full_reg;
    assign rsp.removed_count = removed_reg;

    a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.table_full |-> rsp.removed_count == '0 && rsp.status == STATUS_NONE)
        else $error("table_full with other result fields set");

    a_ban_no_remove: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STATUS_NONE |-> rsp.removed_count == '0)
        else $error("ban reported together with removal");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status != 2'd3)
        else $error("undefined status code");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> rsp_valid_reg && $stable(removed_reg))
        else $error("response register changed while stalled");

endmodule
